[src/lrupr_pkg.sv]
package lrupr_pkg;

    // Default sizing
    localparam int FRAMES_DEFAULT     = 16;
    localparam int PAGE_WIDTH_DEFAULT = 16;

    // Fixed field widths
    localparam int CFG_W           = 5;
    localparam int FRAME_INDEX_W   = 4;
    localparam int FAULT_COUNT_W   = 32;

    // Reset value of the active frame count
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;   // latch the request and clear the scan results
        logic issue;   // read the next frame and advance the walk
        logic commit;  // apply the update and load the result register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic issue_last;  // the frame being read is the last active one
        logic out_free;    // the result register can take a new result
    } status_t;

endpackage

[src/lru_page_replacement_unit.sv]
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_data (frames_in_use, 5 bits)
// in        in         in_valid/in_ready    page
// out       out        out_valid/out_ready  fault, frame_index, evicted_valid,
//                                           evicted_page, fault_count
//
// A request walks the n active frames, n being the active frame count after
// clamping: one shared comparator walks the page RAM one frame a cycle, then
// the drain state lets the last read land and the update state commits.
// Reset clears the valid bits, ranks, fill count and fault counter at once;
// the page RAM holds no reset state. The next request is taken while a result
// waits; a stalled result holds the commit, and with it the next request.
// Configuration writes are taken every cycle.
module lru_page_replacement_unit #(
    parameter int FRAMES     = lrupr_pkg::FRAMES_DEFAULT,
    parameter int PAGE_WIDTH = lrupr_pkg::PAGE_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [PAGE_WIDTH-1:0]               page,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                fault,
    output logic [lrupr_pkg::FRAME_INDEX_W-1:0] frame_index,
    output logic                                evicted_valid,
    output logic [PAGE_WIDTH-1:0]               evicted_page,
    output logic [lrupr_pkg::FAULT_COUNT_W-1:0] fault_count
);

    logic [lrupr_pkg::CFG_W-1:0] frames_in_use_reg;
    lrupr_pkg::cmd_t             cmd;
    lrupr_pkg::status_t          status;

    // Hold the active frame count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= lrupr_pkg::FRAMES_IN_USE_RESET;
        end
        else if (cfg_valid)
        begin
            frames_in_use_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    lrupr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lrupr_datapath #(
        .FRAMES     (FRAMES),
        .PAGE_WIDTH (PAGE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .frames_in_use (frames_in_use_reg),
        .page          (page),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fault         (fault),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

endmodule

[src/lrupr_ram.sv]
module lrupr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/lrupr_ctrl.sv]
module lrupr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lrupr_pkg::status_t status,
    output lrupr_pkg::cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Sequence one request: walk the active frames, drain the read, commit
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A read issued in the walk is always followed by its compare cycle
    a_issue_then_scan_or_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("walk left before the last compare");

    // Only the idle state takes a request
    a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_SCAN))
        else $error("request accepted without starting the walk");

    // Commit only into a free result register
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result overwritten before transfer");

endmodule

[src/lrupr_datapath.sv]
module lrupr_datapath #(
    parameter int FRAMES     = lrupr_pkg::FRAMES_DEFAULT,
    parameter int PAGE_WIDTH = lrupr_pkg::PAGE_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrupr_pkg::cmd_t                     cmd,
    output lrupr_pkg::status_t                  status,
    input  logic [lrupr_pkg::CFG_W-1:0]         frames_in_use,
    input  logic [PAGE_WIDTH-1:0]               page,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                fault,
    output logic [lrupr_pkg::FRAME_INDEX_W-1:0] frame_index,
    output logic                                evicted_valid,
    output logic [PAGE_WIDTH-1:0]               evicted_page,
    output logic [lrupr_pkg::FAULT_COUNT_W-1:0] fault_count
);

    localparam int FW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = FW;
    localparam int CW     = $clog2(FRAMES + 1);
    localparam logic [FW-1:0] LAST_MAX = FW'(FRAMES - 1);
    localparam logic [lrupr_pkg::FAULT_COUNT_W-1:0] FAULT_MAX = '1;

    // Request and walk control
    logic [PAGE_WIDTH-1:0] req_reg;
    logic [FW-1:0]         last_reg;
    logic [FW-1:0]         issue_idx_reg;
    logic                  cmp_live_reg;
    logic [FW-1:0]         cmp_idx_reg;

    // Scan results
    logic                  hit_found_reg;
    logic [FW-1:0]         hit_idx_reg;
    logic [RANK_W-1:0]     hit_rank_reg;
    logic                  empty_found_reg;
    logic [FW-1:0]         empty_idx_reg;
    logic [FW-1:0]         best_idx_reg;
    logic [RANK_W-1:0]     best_rank_reg;
    logic [PAGE_WIDTH-1:0] best_page_reg;

    // Frame state
    logic [FRAMES-1:0]     valid_reg;
    logic [FRAMES-1:0]     valid_next;
    logic [RANK_W-1:0]     rank_reg  [FRAMES];
    logic [RANK_W-1:0]     rank_next [FRAMES];
    logic [CW-1:0]         vcount_reg;
    logic [CW-1:0]         vcount_next;
    logic [lrupr_pkg::FAULT_COUNT_W-1:0] faults_reg;
    logic [lrupr_pkg::FAULT_COUNT_W-1:0] faults_next;

    // Result register
    logic                  out_valid_reg;
    logic                  fault_reg;
    logic [FW-1:0]         frame_reg;
    logic                  evicted_valid_reg;
    logic [PAGE_WIDTH-1:0] evicted_page_reg;
    logic [lrupr_pkg::FAULT_COUNT_W-1:0] fault_count_reg;

    logic [PAGE_WIDTH-1:0] ram_rdata;
    logic [FW-1:0]         last_sel;
    logic                  cmp_valid;
    logic [RANK_W-1:0]     cmp_rank;
    logic                  do_evict;
    logic                  do_touch;
    logic [FW-1:0]         target;
    logic [RANK_W-1:0]     old_rank;

    // Page store
    lrupr_ram #(
        .WIDTH (PAGE_WIDTH),
        .DEPTH (FRAMES)
    ) u_page_ram (
        .clk   (clk),
        .we    (cmd.commit && !hit_found_reg),
        .waddr (target),
        .wdata (req_reg),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    // Clamp the active frame count to one..FRAMES, held as a last index
    always_comb
    begin
        if (frames_in_use == '0)
        begin
            last_sel = '0;
        end
        else if (32'(frames_in_use) > 32'(FRAMES))
        begin
            last_sel = LAST_MAX;
        end
        else
        begin
            last_sel = FW'(frames_in_use - 5'd1);
        end
    end

    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign cmp_rank  = rank_reg[cmp_idx_reg];

    // Walk the frames and track first match, first empty and least recent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg   <= '0;
            cmp_live_reg    <= 1'b0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else
        begin
            cmp_live_reg <= cmd.issue;
            if (cmd.start)
            begin
                issue_idx_reg   <= '0;
                hit_found_reg   <= 1'b0;
                empty_found_reg <= 1'b0;
            end
            else if (cmd.issue)
            begin
                issue_idx_reg <= issue_idx_reg + 1'b1;
            end
            if (cmp_live_reg)
            begin
                if (!hit_found_reg && cmp_valid && ram_rdata == req_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!empty_found_reg && !cmp_valid)
                begin
                    empty_found_reg <= 1'b1;
                end
            end
        end
    end

    // Capture the payload of the walk
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg  <= page;
            last_reg <= last_sel;
        end
        if (cmd.issue)
        begin
            cmp_idx_reg <= issue_idx_reg;
        end
        if (cmp_live_reg)
        begin
            if (!hit_found_reg && cmp_valid && ram_rdata == req_reg)
            begin
                hit_idx_reg  <= cmp_idx_reg;
                hit_rank_reg <= cmp_rank;
            end
            if (!empty_found_reg && !cmp_valid)
            begin
                empty_idx_reg <= cmp_idx_reg;
            end
            if (cmp_idx_reg == '0 || cmp_rank < best_rank_reg)
            begin
                best_idx_reg  <= cmp_idx_reg;
                best_rank_reg <= cmp_rank;
                best_page_reg <= ram_rdata;
            end
        end
    end

    assign status.issue_last = (issue_idx_reg == last_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    // Choose the frame to use and whether it moves to most recent
    always_comb
    begin
        do_evict = !hit_found_reg && !empty_found_reg;
        do_touch = hit_found_reg || do_evict;
        if (hit_found_reg)
        begin
            target   = hit_idx_reg;
            old_rank = hit_rank_reg;
        end
        else if (empty_found_reg)
        begin
            target   = empty_idx_reg;
            old_rank = best_rank_reg;
        end
        else
        begin
            target   = best_idx_reg;
            old_rank = best_rank_reg;
        end
    end

    // Work out the new ranks, valid bits and counters
    always_comb
    begin
        valid_next  = valid_reg;
        vcount_next = vcount_reg;
        faults_next = faults_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.commit)
        begin
            if (do_touch)
            begin
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] > old_rank)
                    begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                rank_next[target] = RANK_W'(vcount_reg - 1'b1);
            end
            else
            begin
                rank_next[target]  = RANK_W'(vcount_reg);
                valid_next[target] = 1'b1;
                vcount_next        = vcount_reg + 1'b1;
            end
            if (!hit_found_reg && faults_reg != FAULT_MAX)
            begin
                faults_next = faults_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            vcount_reg <= '0;
            faults_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg  <= valid_next;
            vcount_reg <= vcount_next;
            faults_reg <= faults_next;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            fault_reg         <= !hit_found_reg;
            frame_reg         <= target;
            evicted_valid_reg <= do_evict;
            evicted_page_reg  <= do_evict ? best_page_reg : '0;
            fault_count_reg   <= faults_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fault         = fault_reg;
    assign frame_index   = lrupr_pkg::FRAME_INDEX_W'(frame_reg);
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_count   = fault_count_reg;

    // The fill count tracks the valid bits
    a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(vcount_reg))
        else $error("fill count out of step with valid bits");

    // A commit always offers a result next cycle
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not offered");

    // An eviction is always a fault
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && evicted_valid_reg) |-> fault_reg)
        else $error("eviction reported on a hit");

endmodule

[verif/lru_page_replacement_unit_tb.sv]
`timescale 1ns / 1ps

module lru_page_replacement_unit_tb;

    localparam int NFRAMES        = lrupr_pkg::FRAMES_DEFAULT;
    localparam int PW             = lrupr_pkg::PAGE_WIDTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic                                fault;
        logic [lrupr_pkg::FRAME_INDEX_W-1:0] frame;
        logic                                evicted;
        logic [PW-1:0]                       victim_page;
        logic [lrupr_pkg::FAULT_COUNT_W-1:0] faults;
    } access_outcome_t;

    logic                                clk           = 1'b0;
    logic                                rst_n         = 1'b0;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [lrupr_pkg::CFG_W-1:0]         cfg_data      = '0;
    logic                                in_valid      = 1'b0;
    logic                                in_ready;
    logic [PW-1:0]                       page          = '0;
    logic                                out_valid;
    logic                                out_ready     = 1'b0;
    logic                                fault;
    logic [lrupr_pkg::FRAME_INDEX_W-1:0] frame_index;
    logic                                evicted_valid;
    logic [PW-1:0]                       evicted_page;
    logic [lrupr_pkg::FAULT_COUNT_W-1:0] fault_count;

    lru_page_replacement_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .page         (page),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fault        (fault),
        .frame_index  (frame_index),
        .evicted_valid(evicted_valid),
        .evicted_page (evicted_page),
        .fault_count  (fault_count)
    );

    // Shadow of the frame table
    logic [PW-1:0]                       shadow_page  [NFRAMES];
    bit                                  shadow_valid [NFRAMES];
    int unsigned                         shadow_rank  [NFRAMES];
    logic [lrupr_pkg::FAULT_COUNT_W-1:0] shadow_faults = '0;
    logic [lrupr_pkg::CFG_W-1:0]         shadow_frames = lrupr_pkg::FRAMES_IN_USE_RESET;

    access_outcome_t access_outcomes[$];

    int unsigned pages_sent    = 0;
    int unsigned outcomes_seen = 0;
    int unsigned hits_seen     = 0;
    int unsigned evicts_seen   = 0;
    int unsigned cfg_writes    = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;

    // Idling controls
    bit          idle_on    = 1'b1;
    bit          stalls_on  = 1'b1;
    bit          hold_req   = 1'b0;
    bit          hold_ack   = 1'b0;
    int unsigned hold_len   = 0;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned active_count();
        if (shadow_frames == 0)
            return 1;
        if (shadow_frames > NFRAMES)
            return NFRAMES;
        return 32'(shadow_frames);
    endfunction

    function automatic int unsigned occupied_count();
        int unsigned v;
        v = 0;
        for (int i = 0; i < NFRAMES; i++)
            if (shadow_valid[i])
                v++;
        return v;
    endfunction

    // Make frame f the most recent, closing the gap it leaves in the ranks
    function automatic void promote_frame(int f);
        int unsigned old_rank;
        int unsigned v;
        old_rank = shadow_rank[f];
        v = occupied_count();
        for (int i = 0; i < NFRAMES; i++)
            if (shadow_valid[i] && shadow_rank[i] > old_rank)
                shadow_rank[i]--;
        shadow_rank[f] = v - 1;
    endfunction

    // Look up one page request and update the shadow table
    function automatic access_outcome_t lru_access(logic [PW-1:0] req);
        access_outcome_t o;
        int unsigned     n;
        int              f;
        bit              hit;
        bit              empty_found;
        n = active_count();
        f = 0;
        hit = 1'b0;
        empty_found = 1'b0;
        o = '0;
        for (int i = 0; i < n; i++)
        begin
            if (!hit && shadow_valid[i] && shadow_page[i] == req)
            begin
                f = i;
                hit = 1'b1;
            end
        end
        if (hit)
        begin
            promote_frame(f);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (!empty_found && !shadow_valid[i])
                begin
                    f = i;
                    empty_found = 1'b1;
                end
            end
            if (empty_found)
            begin
                shadow_rank[f]  = occupied_count();
                shadow_valid[f] = 1'b1;
                shadow_page[f]  = req;
            end
            else
            begin
                f = 0;
                for (int i = 1; i < n; i++)
                    if (shadow_rank[i] < shadow_rank[f])
                        f = i;
                o.evicted     = 1'b1;
                o.victim_page = shadow_page[f];
                shadow_page[f] = req;
                promote_frame(f);
            end
            o.fault = 1'b1;
            if (shadow_faults != '1)
                shadow_faults++;
        end
        o.frame  = f[lrupr_pkg::FRAME_INDEX_W-1:0];
        o.faults = shadow_faults;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Record transfers: check results, track configuration, queue new outcomes
    always @(posedge clk)
    begin
        access_outcome_t o;
        if (rst_n && out_valid && out_ready)
        begin
            if (access_outcomes.size() == 0)
            begin
                report_mismatch("unrequested result", fault_count, 32'd0);
            end
            else
            begin
                o = access_outcomes.pop_front();
                if (fault !== o.fault)
                    report_mismatch("fault", 32'(fault), 32'(o.fault));
                if (frame_index !== o.frame)
                    report_mismatch("frame_index", 32'(frame_index), 32'(o.frame));
                if (evicted_valid !== o.evicted)
                    report_mismatch("evicted_valid", 32'(evicted_valid), 32'(o.evicted));
                if (evicted_page !== o.victim_page)
                    report_mismatch("evicted_page", 32'(evicted_page),
                                    32'(o.victim_page));
                if (fault_count !== o.faults)
                    report_mismatch("fault_count", fault_count, o.faults);
                if (!o.fault)
                    hits_seen++;
                if (o.evicted)
                    evicts_seen++;
            end
            outcomes_seen++;
        end
        if (rst_n && cfg_valid && cfg_ready)
            shadow_frames = cfg_data;
        if (rst_n && in_valid && in_ready)
            access_outcomes.push_back(lru_access(page));
    end

    // Drive the result side: long holds on request, random stall bursts otherwise
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= hold_len;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // End the run when nothing has moved for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one page request, after an optional idle burst, and hold it until taken
    task automatic send_page(input logic [PW-1:0] p);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        page     <= p;
        do @(posedge clk); while (!in_ready);
        pages_sent++;
    endtask

    // Drop the request and wait until every outstanding result has come back
    task automatic wait_for_outcomes();
        in_valid <= 1'b0;
        do @(posedge clk); while (outcomes_seen < pages_sent);
    endtask

    task automatic set_frames(input logic [lrupr_pkg::CFG_W-1:0] n);
        wait_for_outcomes();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Fill from empty with the reset frame count, then a hit and two evictions
    task automatic test_reset_fill();
        send_page('0);
        send_page('1);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page('0);
        send_page(16'h0003);
        send_page('1);
    endtask

    // A count of zero acts as one frame; counts above the table saturate
    task automatic test_frame_count_limits();
        set_frames(5'd0);
        send_page(16'h0005);
        send_page(16'h0006);
        send_page(16'h0005);
        set_frames(5'd31);
        send_page(16'h0007);
        send_page(16'h0008);
        send_page(16'h0009);
        send_page(16'h0005);
    endtask

    // Shrink so a resident page falls outside the active set, reload it, then
    // grow again so it is resident twice and the lower frame must hit
    task automatic test_shrink_and_duplicate();
        logic [PW-1:0] stranded;
        set_frames(5'd4);
        for (int i = 0; i < 4; i++)
            send_page(PW'(16'hA000 + i));
        wait_for_outcomes();
        stranded = shadow_page[3];
        set_frames(5'd2);
        send_page(stranded);
        set_frames(5'd4);
        send_page(stranded);
    endtask

    // Phases of working-set traffic with random content and some noise
    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [PW-1:0]               working_set[24];
        int unsigned                 ws_size;
        logic [lrupr_pkg::CFG_W-1:0] n;
        for (int i = 0; i < 24; i++)
            working_set[i] = PW'($urandom);
        for (int ph = 0; ph < phases; ph++)
        begin
            case ($urandom_range(0, 7))
                0:       n = 5'd0;
                1:       n = 5'd1;
                2:       n = 5'd16;
                3:       n = 5'd31;
                4:       n = lrupr_pkg::CFG_W'($urandom_range(17, 30));
                default: n = lrupr_pkg::CFG_W'($urandom_range(2, 15));
            endcase
            set_frames(n);
            // keep part of the old set so pages left in idle frames come back
            for (int i = 0; i < 24; i++)
                if ($urandom_range(0, 1) == 0)
                    working_set[i] = PW'($urandom);
            ws_size = active_count() + $urandom_range(0, 4);
            for (int k = 0; k < per_phase; k++)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_page(PW'($urandom_range(0, 65535)));
                else
                    send_page(working_set[$urandom_range(0, ws_size - 1)]);
            end
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // then pause the sender until everything has drained and send ten more
    task automatic test_backpressure();
        set_frames(5'd16);
        hold_len <= 250;
        hold_req <= ~hold_req;
        for (int i = 0; i < 12; i++)
            send_page(PW'($urandom_range(0, 31)));
        wait_for_outcomes();
        for (int i = 0; i < 10; i++)
            send_page(PW'($urandom_range(0, 31)));
    endtask

    // Back-to-back requests with no idling on either side
    task automatic test_streaming(input int count);
        idle_on = 1'b0;
        stalls_on <= 1'b0;
        set_frames(5'd8);
        for (int i = 0; i < count; i++)
            send_page(PW'($urandom_range(0, 11)));
    endtask

    initial
    begin
        for (int i = 0; i < NFRAMES; i++)
        begin
            shadow_page[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_fill();
        test_frame_count_limits();
        test_shrink_and_duplicate();
        test_random_traffic(16, 100);
        test_backpressure();
        test_streaming(200);

        wait_for_outcomes();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (access_outcomes.size() != 0)
            report_mismatch("results never returned", access_outcomes.size(), 32'd0);

        $display("Sent %0d page requests over %0d frame-count writes: %0d hits, %0d evictions",
                 pages_sent, cfg_writes, hits_seen, evicts_seen);
        $display("%0d mismatches recorded", error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
